// ===== rtl/hidks_pkg.sv =====
// ============================================================================
// hidks_pkg
// Shared types and constants for the ASCII to HID keystroke sequencer.
// ============================================================================
package hidks_pkg;

    localparam int TABLE_DEPTH = 128;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CHAR_W      = 8;
    localparam int WORD_W      = 16;
    localparam int MOD_W       = 8;
    localparam int KEY_W       = 8;

    localparam logic [CHAR_W-1:0] MAX_CHAR    = 8'd127;
    localparam logic [IDX_W-1:0]  SPACE_INDEX = IDX_W'(32);

    localparam int FLAG_SHIFT_BIT = 8;
    localparam int FLAG_LALT_BIT  = 9;
    localparam int FLAG_RALT_BIT  = 10;
    localparam int FLAG_DEAD_BIT  = 11;

    localparam logic [MOD_W-1:0] MODBIT_LSHIFT = 8'h02;
    localparam logic [MOD_W-1:0] MODBIT_LALT   = 8'h04;
    localparam logic [MOD_W-1:0] MODBIT_RALT   = 8'h40;

    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_SET    = 2'd1,
        CMD_NEXT   = 2'd2,
        CMD_UNUSED = 2'd3
    } cmd_e_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_NOENT   = 2'd2
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } state_t;

    typedef struct packed {
        logic              set_en;
        logic              next_en;
        logic [WORD_W-1:0] set_word;
        logic [KEY_W-1:0]  space_key;
    } seq_req_t;

    typedef struct packed {
        status_t          status;
        logic [MOD_W-1:0] mods;
        logic [KEY_W-1:0] key;
    } rpt_t;

endpackage

// ===== rtl/hidks_cmd_if.sv =====
// ============================================================================
// hidks_cmd_if
// Command channel: valid/ready handshake with command, char and map word.
// ============================================================================
interface hidks_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [7:0]  char_code;
    logic [15:0] table_word;

    modport source (output valid, output command, output char_code,
                    output table_word, input ready);
    modport sink   (input valid, input command, input char_code,
                    input table_word, output ready);
endinterface

// ===== rtl/hidks_rpt_if.sv =====
// ============================================================================
// hidks_rpt_if
// Report channel: valid/ready handshake with status and HID report bytes.
// ============================================================================
interface hidks_rpt_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [7:0] modifier_bits;
    logic [7:0] key_code;

    modport source (output valid, output status, output modifier_bits,
                    output key_code, input ready);
    modport sink   (input valid, input status, input modifier_bits,
                    input key_code, output ready);
endinterface

// ===== rtl/hidks_keymap.sv =====
// ============================================================================
// hidks_keymap
// Keymap memory, one write and one registered read port. Per-entry valid
// bits make unwritten entries read as zero right after reset.
// ============================================================================
module hidks_keymap (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                wr_en,
    input  logic [hidks_pkg::IDX_W-1:0]         wr_addr,
    input  logic [hidks_pkg::WORD_W-1:0]        wr_data,
    input  logic                                rd_en,
    input  logic [hidks_pkg::IDX_W-1:0]         rd_addr,
    output logic [hidks_pkg::WORD_W-1:0]        rd_data
);

    logic [hidks_pkg::WORD_W-1:0]      mem [hidks_pkg::TABLE_DEPTH];
    logic [hidks_pkg::TABLE_DEPTH-1:0] vld_reg;
    logic [hidks_pkg::WORD_W-1:0]      rd_word_reg;
    logic                              rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_word_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_vld_reg ? rd_word_reg : '0;

    // read and write never share a command
    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && rd_en))
        else $error("keymap read and write in the same cycle");

    a_wr_marks_valid: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> vld_reg[$past(wr_addr)])
        else $error("written entry not marked valid");

endmodule

// ===== rtl/hidks_seq.sv =====
// ============================================================================
// hidks_seq
// Pending keystroke state and report priority logic.
// ============================================================================
module hidks_seq (
    input  logic                clk,
    input  logic                rst_n,
    input  hidks_pkg::seq_req_t req,
    output hidks_pkg::rpt_t     rpt
);

    logic [hidks_pkg::MOD_W-1:0] mods_reg, mods_next;
    logic [hidks_pkg::KEY_W-1:0] scan_reg, scan_next;
    logic                        dead_reg, dead_next;
    logic                        rel_reg, rel_next;
    logic                        sent_reg, sent_next;
    logic [hidks_pkg::MOD_W-1:0] set_mods;

    always_comb
    begin
        set_mods = '0;
        if (req.set_word[hidks_pkg::FLAG_SHIFT_BIT])
        begin
            set_mods = set_mods | hidks_pkg::MODBIT_LSHIFT;
        end
        if (req.set_word[hidks_pkg::FLAG_LALT_BIT])
        begin
            set_mods = set_mods | hidks_pkg::MODBIT_LALT;
        end
        if (req.set_word[hidks_pkg::FLAG_RALT_BIT])
        begin
            set_mods = set_mods | hidks_pkg::MODBIT_RALT;
        end
    end

    always_comb
    begin
        mods_next = mods_reg;
        scan_next = scan_reg;
        dead_next = dead_reg;
        rel_next  = rel_reg;
        sent_next = sent_reg;
        rpt.status = hidks_pkg::ST_OK;
        rpt.mods   = '0;
        rpt.key    = '0;
        if (req.set_en)
        begin
            mods_next = mods_reg | set_mods;
            scan_next = req.set_word[hidks_pkg::KEY_W-1:0];
            dead_next = req.set_word[hidks_pkg::FLAG_DEAD_BIT];
            sent_next = 1'b0;
        end
        else if (req.next_en)
        begin
            priority if (mods_reg != '0 && !sent_reg)
            begin
                sent_next = 1'b1;
                rpt.mods  = mods_reg;
            end
            else if (rel_reg)
            begin
                rpt.mods = mods_reg;
                if (mods_reg != '0)
                begin
                    mods_next = '0;
                end
                else
                begin
                    rel_next = 1'b0;
                end
            end
            else if (scan_reg != '0)
            begin
                rpt.mods  = mods_reg;
                rpt.key   = scan_reg;
                scan_next = '0;
                rel_next  = 1'b1;
            end
            else if (dead_reg)
            begin
                rpt.key   = req.space_key;
                dead_next = 1'b0;
                rel_next  = 1'b1;
            end
            else
            begin
                rpt.status = hidks_pkg::ST_NOENT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mods_reg <= '0;
            scan_reg <= '0;
            dead_reg <= 1'b0;
            rel_reg  <= 1'b0;
            sent_reg <= 1'b0;
        end
        else
        begin
            mods_reg <= mods_next;
            scan_reg <= scan_next;
            dead_reg <= dead_next;
            rel_reg  <= rel_next;
            sent_reg <= sent_next;
        end
    end

    a_key_arms_release: assert property (@(posedge clk) disable iff (!rst_n)
        (req.next_en && !req.set_en && rpt.key != '0) |=> rel_reg)
        else $error("key press did not arm release");

    a_noent_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (req.next_en && !req.set_en && rpt.status == hidks_pkg::ST_NOENT)
        |-> (scan_reg == '0 && !dead_reg && !rel_reg))
        else $error("no-entry while a keystroke is pending");

endmodule

// ===== rtl/ascii_to_hid_keystroke_sequencer.sv =====
// ============================================================================
// ascii_to_hid_keystroke_sequencer
// Command decode, keymap access and report output register.
// ============================================================================
//  channel | dir | fields
//  cmd     | in  | command, char_code, table_word
//  rpt     | out | status, modifier_bits, key_code
//
//  Each command is accepted in idle and completes in execute, which uses the registered keymap read.
//  Command 3 is accepted without entering execute and gives no word.
//  Reset clears the keymap valid bits and all pending state at once.
//  A report not taken holds the block in execute until the output frees up.
module ascii_to_hid_keystroke_sequencer (
    input  logic              clk,
    input  logic              rst_n,
    hidks_cmd_if.sink         cmd,
    hidks_rpt_if.source       rpt
);

    hidks_pkg::state_t                state_reg, state_next;
    logic [1:0]                       cmd_reg;
    logic [hidks_pkg::CHAR_W-1:0]     chr_reg;
    logic                             out_valid_reg, out_valid_next;
    hidks_pkg::rpt_t                  out_reg, out_next;

    logic                             accept;
    logic                             is_load, is_set, is_next;
    logic                             load_in_range;
    logic                             out_free;
    logic                             finish;
    logic [hidks_pkg::WORD_W-1:0]     rd_data;
    logic [hidks_pkg::IDX_W-1:0]      rd_addr;
    hidks_pkg::seq_req_t              req;
    hidks_pkg::rpt_t                  seq_rpt;
    logic                             set_bad;

    assign accept  = cmd.valid && cmd.ready;
    assign is_load = (cmd.command == hidks_pkg::CMD_LOAD);
    assign is_set  = (cmd.command == hidks_pkg::CMD_SET);
    assign is_next = (cmd.command == hidks_pkg::CMD_NEXT);
    assign load_in_range = ({1'b0, cmd.char_code} < 9'(hidks_pkg::TABLE_DEPTH));
    assign rd_addr = is_set ? cmd.char_code[hidks_pkg::IDX_W-1:0]
                            : hidks_pkg::SPACE_INDEX;
    assign out_free = !out_valid_reg || rpt.ready;

    hidks_keymap u_keymap (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept && is_load && load_in_range),
        .wr_addr (cmd.char_code[hidks_pkg::IDX_W-1:0]),
        .wr_data (cmd.table_word),
        .rd_en   (accept && (is_set || is_next)),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign set_bad = (chr_reg > hidks_pkg::MAX_CHAR) || (rd_data == '0);

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !rpt.ready;
        out_next       = out_reg;
        finish         = 1'b0;
        req.set_en     = 1'b0;
        req.next_en    = 1'b0;
        req.set_word   = rd_data;
        req.space_key  = rd_data[hidks_pkg::KEY_W-1:0];
        unique case (state_reg)
            hidks_pkg::S_IDLE:
            begin
                if (accept && (is_load || is_set || is_next))
                begin
                    state_next = hidks_pkg::S_EXEC;
                end
            end
            hidks_pkg::S_EXEC:
            begin
                if (out_free)
                begin
                    finish         = 1'b1;
                    state_next     = hidks_pkg::S_IDLE;
                    out_valid_next = 1'b1;
                    out_next.status = hidks_pkg::ST_OK;
                    out_next.mods   = '0;
                    out_next.key    = '0;
                    if (cmd_reg == hidks_pkg::CMD_SET)
                    begin
                        if (set_bad)
                        begin
                            out_next.status = hidks_pkg::ST_INVALID;
                        end
                        else
                        begin
                            req.set_en = 1'b1;
                        end
                    end
                    else if (cmd_reg == hidks_pkg::CMD_NEXT)
                    begin
                        req.next_en = 1'b1;
                        out_next    = seq_rpt;
                    end
                end
            end
            default:
            begin
                state_next = hidks_pkg::S_IDLE;
            end
        endcase
    end

    hidks_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rpt   (seq_rpt)
    );

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd.command;
            chr_reg <= cmd.char_code;
        end
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hidks_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign cmd.ready         = (state_reg == hidks_pkg::S_IDLE);
    assign rpt.valid         = out_valid_reg;
    assign rpt.status        = out_reg.status;
    assign rpt.modifier_bits = out_reg.mods;
    assign rpt.key_code      = out_reg.key;

    a_cmd_starts_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd.command != hidks_pkg::CMD_UNUSED)
        |=> state_reg == hidks_pkg::S_EXEC)
        else $error("accepted command did not start execution");

    a_finish_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
        finish |=> (rpt.valid && state_reg == hidks_pkg::S_IDLE))
        else $error("finished command produced no word");

endmodule

// ===== tb/sv/hid_report_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// hid_report_checker
// Watches the command and report channels of the keystroke sequencer, keeps
// its own copy of the keymap and the pending keystroke state, and compares
// every report word against the oldest predicted one, field by field.
// ============================================================================
module hid_report_checker (
    input  logic  clk,
    input  logic  rst_n,
    hidks_cmd_if  cmd,
    hidks_rpt_if  rpt,
    output int    errors,
    output int    pending
);

    logic [hidks_pkg::WORD_W-1:0] keymap [hidks_pkg::TABLE_DEPTH];
    logic [hidks_pkg::MOD_W-1:0]  held_mods;
    logic [hidks_pkg::KEY_W-1:0]  held_scan;
    logic                         dead_flag;
    logic                         release_flag;
    logic                         mods_out;

    hidks_pkg::rpt_t reports_due [$];
    hidks_pkg::rpt_t want_rpt;
    int              fail_count = 0;

    assign errors = fail_count;

    task automatic report_mismatch(input string what, input int want, input int got);
        $display("%0t hid_report_checker: %s: expected %0h, got %0h", $time, what, want, got);
        fail_count++;
    endtask

    // Returns 0 when the command gives no word.
    function automatic bit hid_report_for(input logic [1:0] op,
                                          input logic [hidks_pkg::CHAR_W-1:0] chr,
                                          input logic [hidks_pkg::WORD_W-1:0] word,
                                          output hidks_pkg::rpt_t r);
        logic [hidks_pkg::WORD_W-1:0] w;
        r.status = hidks_pkg::ST_OK;
        r.mods   = '0;
        r.key    = '0;
        case (op)
            hidks_pkg::CMD_LOAD:
            begin
                if (chr < hidks_pkg::TABLE_DEPTH)
                begin
                    keymap[chr[hidks_pkg::IDX_W-1:0]] = word;
                end
            end
            hidks_pkg::CMD_SET:
            begin
                w = (chr > hidks_pkg::MAX_CHAR) ? '0 : keymap[chr[hidks_pkg::IDX_W-1:0]];
                if (w == '0)
                begin
                    r.status = hidks_pkg::ST_INVALID;
                end
                else
                begin
                    mods_out = 1'b0;
                    if (w[hidks_pkg::FLAG_SHIFT_BIT])
                        held_mods = held_mods | hidks_pkg::MODBIT_LSHIFT;
                    if (w[hidks_pkg::FLAG_LALT_BIT])
                        held_mods = held_mods | hidks_pkg::MODBIT_LALT;
                    if (w[hidks_pkg::FLAG_RALT_BIT])
                        held_mods = held_mods | hidks_pkg::MODBIT_RALT;
                    held_scan = w[hidks_pkg::KEY_W-1:0];
                    dead_flag = w[hidks_pkg::FLAG_DEAD_BIT];
                end
            end
            hidks_pkg::CMD_NEXT:
            begin
                if (held_mods != '0 && !mods_out)
                begin
                    mods_out = 1'b1;
                    r.mods   = held_mods;
                end
                else if (release_flag)
                begin
                    r.mods = held_mods;
                    if (held_mods != '0)
                        held_mods = '0;
                    else
                        release_flag = 1'b0;
                end
                else if (held_scan != '0)
                begin
                    r.mods       = held_mods;
                    r.key        = held_scan;
                    held_scan    = '0;
                    release_flag = 1'b1;
                end
                else if (dead_flag)
                begin
                    r.key        = keymap[hidks_pkg::SPACE_INDEX][hidks_pkg::KEY_W-1:0];
                    dead_flag    = 1'b0;
                    release_flag = 1'b1;
                end
                else
                begin
                    r.status = hidks_pkg::ST_NOENT;
                end
            end
            default:
            begin
                return 1'b0;
            end
        endcase
        return 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < hidks_pkg::TABLE_DEPTH; i++)
                keymap[i] = '0;
            held_mods    = '0;
            held_scan    = '0;
            dead_flag    = 1'b0;
            release_flag = 1'b0;
            mods_out     = 1'b0;
            reports_due.delete();
            pending <= 0;
        end
        else
        begin
            if (cmd.valid && cmd.ready)
            begin
                if (hid_report_for(cmd.command, cmd.char_code, cmd.table_word, want_rpt))
                    reports_due.push_back(want_rpt);
            end
            if (rpt.valid && rpt.ready)
            begin
                if (reports_due.size() == 0)
                begin
                    report_mismatch("report word with none expected", 0,
                                    int'({rpt.status, rpt.modifier_bits, rpt.key_code}));
                end
                else
                begin
                    want_rpt = reports_due.pop_front();
                    if (rpt.status !== want_rpt.status)
                        report_mismatch("status", int'(want_rpt.status), int'(rpt.status));
                    if (rpt.modifier_bits !== want_rpt.mods)
                        report_mismatch("modifier_bits", int'(want_rpt.mods),
                                        int'(rpt.modifier_bits));
                    if (rpt.key_code !== want_rpt.key)
                        report_mismatch("key_code", int'(want_rpt.key), int'(rpt.key_code));
                end
            end
            pending <= reports_due.size();
        end
    end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Drives the keystroke sequencer with a short directed run (keymap loads,
// rejected characters, full and dead-key sequences, set while busy, unused
// command) and then random keystroke sequences with noise, under random
// gaps and stalls on both channels. The checker predicts and compares.
// ============================================================================
module testbench;

    localparam int          RUN_ITEMS   = 650;
    localparam int          CYCLE_LIMIT = 400000;
    localparam int          MAX_IDLE    = 17;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    int unsigned cycles = 0;
    int tx_max = MAX_IDLE;
    int rx_max = MAX_IDLE;
    int sent   = 0;
    int errors;
    int pending;
    bit mapped [hidks_pkg::TABLE_DEPTH];

    hidks_cmd_if cmd_ch ();
    hidks_rpt_if rpt_ch ();

    ascii_to_hid_keystroke_sequencer u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rpt   (rpt_ch)
    );

    hid_report_checker u_checker (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd_ch),
        .rpt     (rpt_ch),
        .errors  (errors),
        .pending (pending)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    task automatic send_word(input logic [1:0] op,
                             input logic [hidks_pkg::CHAR_W-1:0] chr,
                             input logic [hidks_pkg::WORD_W-1:0] word);
        int gap;
        gap = $urandom_range(0, tx_max);
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid      <= 1'b1;
        cmd_ch.command    <= op;
        cmd_ch.char_code  <= chr;
        cmd_ch.table_word <= word;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        if (op == hidks_pkg::CMD_LOAD && chr < hidks_pkg::TABLE_DEPTH)
            mapped[chr[hidks_pkg::IDX_W-1:0]] = (word != '0);
        if (op != hidks_pkg::CMD_UNUSED)
            sent++;
    endtask

    // called right at an acceptance edge
    task automatic drain_reports();
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    function automatic logic [hidks_pkg::CHAR_W-1:0] pick_mapped();
        logic [hidks_pkg::CHAR_W-1:0] c;
        for (int t = 0; t < 8; t++)
        begin
            c = 8'($urandom_range(0, 127));
            if (mapped[c[hidks_pkg::IDX_W-1:0]])
                return c;
        end
        return 8'd65;
    endfunction

    // report sink
    initial
    begin
        int stall;
        rpt_ch.ready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            stall = $urandom_range(0, rx_max);
            if (stall > 0)
            begin
                rpt_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rpt_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!rpt_ch.valid);
        end
    end

    initial
    begin
        int                           sel;
        int                           steps;
        int                           next_shuffle;
        bit                           paused;
        logic [hidks_pkg::CHAR_W-1:0] idx;
        logic [hidks_pkg::WORD_W-1:0] word;

        next_shuffle = 0;
        paused       = 1'b0;
        cmd_ch.valid      <= 1'b0;
        cmd_ch.command    <= hidks_pkg::CMD_NEXT;
        cmd_ch.char_code  <= '0;
        cmd_ch.table_word <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed
        send_word(hidks_pkg::CMD_NEXT, 8'h00, 16'h0000);
        send_word(hidks_pkg::CMD_SET, 8'd65, 16'hffff);
        send_word(hidks_pkg::CMD_SET, 8'd200, 16'h0000);
        send_word(hidks_pkg::CMD_LOAD, 8'd32, 16'h002c);
        send_word(hidks_pkg::CMD_LOAD, 8'd65, 16'h0104);
        send_word(hidks_pkg::CMD_LOAD, 8'd200, 16'hffff);
        send_word(hidks_pkg::CMD_SET, 8'd65, 16'h0000);
        repeat (5) send_word(hidks_pkg::CMD_NEXT, 8'hff, 16'h0000);
        send_word(hidks_pkg::CMD_LOAD, 8'd127, 16'hffff);
        send_word(hidks_pkg::CMD_SET, 8'd127, 16'h0000);
        repeat (7) send_word(hidks_pkg::CMD_NEXT, 8'h00, 16'hffff);
        send_word(hidks_pkg::CMD_SET, 8'd65, 16'h0000);
        send_word(hidks_pkg::CMD_NEXT, 8'h00, 16'h0000);
        send_word(hidks_pkg::CMD_SET, 8'd127, 16'h0000);
        send_word(hidks_pkg::CMD_UNUSED, 8'hff, 16'hffff);
        drain_reports();

        // random keystroke sequences with noise
        while (sent < RUN_ITEMS)
        begin
            if (sent >= next_shuffle)
            begin
                tx_max = ($urandom_range(0, 3) == 0) ? 0 : MAX_IDLE;
                rx_max = ($urandom_range(0, 3) == 0) ? 0 : MAX_IDLE;
                next_shuffle += 60;
            end
            if (!paused && sent >= RUN_ITEMS / 2)
            begin
                drain_reports();
                paused = 1'b1;
            end
            sel = $urandom_range(0, 99);
            if (sel < 12)
            begin
                idx  = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(128, 255))
                                                   : 8'($urandom_range(0, 127));
                word = 16'($urandom_range(0, 65535));
                case ($urandom_range(0, 9))
                    0: word = '0;
                    1: word[7:0] = '0;
                    2, 3: word[11:8] = '0;
                    default: ;
                endcase
                send_word(hidks_pkg::CMD_LOAD, idx, word);
            end
            else if (sel < 67)
            begin
                send_word(hidks_pkg::CMD_SET, pick_mapped(), 16'($urandom_range(0, 65535)));
                steps = $urandom_range(2, 8);
                repeat (steps)
                begin
                    if ($urandom_range(0, 9) == 0)
                        send_word(hidks_pkg::CMD_SET, pick_mapped(),
                                  16'($urandom_range(0, 65535)));
                    else
                        send_word(hidks_pkg::CMD_NEXT, 8'($urandom_range(0, 255)),
                                  16'($urandom_range(0, 65535)));
                end
            end
            else if (sel < 77)
                send_word(hidks_pkg::CMD_SET, 8'($urandom_range(0, 255)),
                          16'($urandom_range(0, 65535)));
            else if (sel < 95)
                send_word(hidks_pkg::CMD_NEXT, 8'($urandom_range(0, 255)),
                          16'($urandom_range(0, 65535)));
            else
                send_word(hidks_pkg::CMD_UNUSED, 8'($urandom_range(0, 255)),
                          16'($urandom_range(0, 65535)));
        end

        drain_reports();
        repeat (10) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/hidks_pkg.sv
rtl/hidks_cmd_if.sv
rtl/hidks_rpt_if.sv
rtl/hidks_keymap.sv
rtl/hidks_seq.sv
rtl/ascii_to_hid_keystroke_sequencer.sv
tb/sv/hid_report_checker.sv
tb/sv/testbench.sv
